/* rtl/pdi_pkg.sv */
// pdi_pkg: widths, the per-cell data type and the step-bit helper
// shared by the planar distance front end, the root cells and the top level
// no dependencies
package pdi_pkg;

  localparam int CoordW     = 16;
  localparam int DiffW      = CoordW + 1;
  localparam int ProdW      = 2 * DiffW;
  localparam int SumW       = 32;
  localparam int RootW      = 16;
  localparam int NumSteps   = RootW;
  localparam int FirstShift = SumW - 2;

  // remainder and partial root, the root held scaled so the trial value is res | bit
  typedef struct packed {
    logic [SumW-1:0] rem;
    logic [SumW-1:0] res;
  } cell_data_t;

  // weight of the trial bit for the cell at position idx
  function automatic logic [SumW-1:0] step_bit(input int idx);
    logic [SumW-1:0] one;
    one = {{(SumW-1){1'b0}}, 1'b1};
    return one << (FirstShift - 2 * idx);
  endfunction

endpackage

/* rtl/planar_distance_isqrt.sv */
// planar_distance_isqrt: floor root of the wrapped squared planar distance, exact for sums below 2^31
// an accepted item passes through 3 front stages
// (difference, square, sum) then a chain of 16 root cells, one bit each
// throughput one item per cycle; every stage holds its item under stall
// and takes a new one as soon as it is free
// synchronous active-low reset clears all valid flags, payload is not reset
module planar_distance_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pdi_pkg::CoordW-1:0]  in_target_x,
  input  logic [pdi_pkg::CoordW-1:0]  in_target_z,
  input  logic [pdi_pkg::CoordW-1:0]  in_origin_x,
  input  logic [pdi_pkg::CoordW-1:0]  in_origin_z,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pdi_pkg::RootW-1:0]   out_distance
);
  import pdi_pkg::*;

  logic            front_ready;
  logic [SumW-1:0] front_sum;
  logic            link_v   [0:NumSteps];
  logic            link_rdy [0:NumSteps];
  cell_data_t      link_d   [0:NumSteps];

  pdi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (front_ready),
    .target_x (in_target_x),
    .target_z (in_target_z),
    .origin_x (in_origin_x),
    .origin_z (in_origin_z),
    .dn_valid (link_v[0]),
    .dn_ready (link_rdy[0]),
    .dn_sum   (front_sum)
  );

  assign link_d[0].rem = front_sum;
  assign link_d[0].res = '0;

  for (genvar i = 0; i < NumSteps; i++) begin : g_cell
    pdi_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .bit_w    (step_bit(i)),
      .up_valid (link_v[i]),
      .up_ready (link_rdy[i]),
      .up_data  (link_d[i]),
      .dn_valid (link_v[i+1]),
      .dn_ready (link_rdy[i+1]),
      .dn_data  (link_d[i+1])
    );
  end

  assign link_rdy[NumSteps] = !out_stall;
  assign in_stall           = !front_ready;
  assign out_valid          = link_v[NumSteps];
  assign out_distance       = link_d[NumSteps].res[RootW-1:0];

endmodule

/* rtl/pdi_front.sv */
// pdi_front: coordinate differences, squares and the wrapped sum of squares
// three elastic stages; uses pdi_pkg
module pdi_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic [pdi_pkg::CoordW-1:0]   target_x,
  input  logic [pdi_pkg::CoordW-1:0]   target_z,
  input  logic [pdi_pkg::CoordW-1:0]   origin_x,
  input  logic [pdi_pkg::CoordW-1:0]   origin_z,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic [pdi_pkg::SumW-1:0]     dn_sum
);
  import pdi_pkg::*;

  logic                    diff_v_r, sq_v_r, sum_v_r;
  logic                    diff_rdy, sq_rdy, sum_rdy;
  logic signed [DiffW-1:0] dx_r, dz_r, dx_nxt, dz_nxt;
  logic [SumW-1:0]         sqx_r, sqz_r, sqx_nxt, sqz_nxt;
  logic [SumW-1:0]         sum_r, sum_nxt;
  logic signed [ProdW-1:0] prod_x, prod_z;

  assign sum_rdy  = !sum_v_r  || dn_ready;
  assign sq_rdy   = !sq_v_r   || sum_rdy;
  assign diff_rdy = !diff_v_r || sq_rdy;
  assign up_ready = diff_rdy;

  always_comb begin
    dx_nxt  = $signed({target_x[CoordW-1], target_x}) - $signed({origin_x[CoordW-1], origin_x});
    dz_nxt  = $signed({target_z[CoordW-1], target_z}) - $signed({origin_z[CoordW-1], origin_z});
    prod_x  = dx_r * dx_r;
    prod_z  = dz_r * dz_r;
    sqx_nxt = prod_x[SumW-1:0];
    sqz_nxt = prod_z[SumW-1:0];
    sum_nxt = sqx_r + sqz_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_v_r <= 1'b0;
      sq_v_r   <= 1'b0;
      sum_v_r  <= 1'b0;
    end else begin
      if (diff_rdy) diff_v_r <= up_valid;
      if (sq_rdy)   sq_v_r   <= diff_v_r;
      if (sum_rdy)  sum_v_r  <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (diff_rdy && up_valid) begin
      dx_r <= dx_nxt;
      dz_r <= dz_nxt;
    end
    if (sq_rdy && diff_v_r) begin
      sqx_r <= sqx_nxt;
      sqz_r <= sqz_nxt;
    end
    if (sum_rdy && sq_v_r) begin
      sum_r <= sum_nxt;
    end
  end

  assign dn_valid = sum_v_r;
  assign dn_sum   = sum_r;

endmodule

/* rtl/pdi_cell.sv */
// pdi_cell: one restoring square-root step with signed 32-bit compare
// elastic register stage; uses pdi_pkg
module pdi_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pdi_pkg::SumW-1:0]    bit_w,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  pdi_pkg::cell_data_t         up_data,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output pdi_pkg::cell_data_t         dn_data
);
  import pdi_pkg::*;

  logic            valid_r;
  cell_data_t      data_r, data_nxt;
  logic [SumW-1:0] trial;
  logic            take;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    // partial root bits never overlap the trial bit
    trial        = up_data.res | bit_w;
    take         = $signed(up_data.rem) >= $signed(trial);
    data_nxt.rem = take ? (up_data.rem - trial) : up_data.rem;
    data_nxt.res = (up_data.res >> 1) | (take ? bit_w : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

/* rtl/pdi_checker.sv */
// pdi_checker: port-level checks of the planar distance block over time
// bound to planar_distance_isqrt; uses pdi_pkg for widths
module pdi_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [pdi_pkg::RootW-1:0]   out_distance
);
  import pdi_pkg::*;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance))
    else $error("stalled result dropped or changed");

  // an empty or moving output never back-pressures the input
  a_no_spurious_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // input stalls only when a finished item is held at the output
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output not held");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // input stall only rises right after an item entered the first stage
  a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid))
    else $error("input stall rose without an item entering");

endmodule

bind planar_distance_isqrt pdi_checker u_pdi_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_distance (out_distance)
);
